FILE: hw/rtl/b2da_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg: shared constants and types of the binary to decimal ASCII block
// Widths of the number, the BCD digit register and the handoff word between
// the converter and the digit emitter.
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CHAR_WIDTH  = 6;
   localparam int DIGIT_WIDTH = 4;
   localparam int MAX_DIGITS  = 10;
   localparam int DIGIT_CAP   = 10;
   localparam int DIGITS      = (MAX_DIGITS > DIGIT_CAP) ? DIGIT_CAP :
                                ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
   localparam int BCD_WIDTH   = DIGITS * DIGIT_WIDTH;
   localparam int COUNT_WIDTH = $clog2(DIGITS + 1);
   localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);

   localparam logic [STEP_WIDTH-1:0]  STEP_LAST  = STEP_WIDTH'(VALUE_WIDTH - 1);
   localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO = CHAR_WIDTH'(48);
   localparam logic [DIGIT_WIDTH-1:0] BCD_FIVE   = DIGIT_WIDTH'(5);
   localparam logic [DIGIT_WIDTH-1:0] BCD_THREE  = DIGIT_WIDTH'(3);

   typedef struct packed {
      logic                 valid;
      logic [BCD_WIDTH-1:0] bcd;
   } handoff_type;

endpackage

FILE: hw/rtl/b2da_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_dabble: bit-serial binary to BCD converter
// Shifts the number in one bit per cycle and corrects each BCD digit before
// the shift, then holds the digits until the emitter takes them.
// ----------------------------------------------------------------------------
module b2da_dabble (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0]    value,
   input  logic                                take,
   output logic                                busy,
   output b2da_pkg::handoff_type               handoff
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SHIFT = 3'b010,
      ST_DONE  = 3'b100
   } state_type;

   state_type                             state_ff, state_in;
   logic [b2da_pkg::VALUE_WIDTH-1:0]      value_ff, value_in;
   logic [b2da_pkg::BCD_WIDTH-1:0]        bcd_ff, bcd_in;
   logic [b2da_pkg::BCD_WIDTH-1:0]        bcd_adj;
   logic [b2da_pkg::STEP_WIDTH-1:0]       step_ff, step_in;

   always_comb begin
      for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
         if (bcd_ff[i*b2da_pkg::DIGIT_WIDTH +: b2da_pkg::DIGIT_WIDTH] >=
             b2da_pkg::BCD_FIVE) begin
            bcd_adj[i*b2da_pkg::DIGIT_WIDTH +: b2da_pkg::DIGIT_WIDTH] =
               bcd_ff[i*b2da_pkg::DIGIT_WIDTH +: b2da_pkg::DIGIT_WIDTH] +
               b2da_pkg::BCD_THREE;
         end else begin
            bcd_adj[i*b2da_pkg::DIGIT_WIDTH +: b2da_pkg::DIGIT_WIDTH] =
               bcd_ff[i*b2da_pkg::DIGIT_WIDTH +: b2da_pkg::DIGIT_WIDTH];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      value_in = value_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = value;
               bcd_in   = '0;
               step_in  = '0;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            bcd_in   = {bcd_adj[b2da_pkg::BCD_WIDTH-2:0],
                        value_ff[b2da_pkg::VALUE_WIDTH-1]};
            value_in = {value_ff[b2da_pkg::VALUE_WIDTH-2:0], 1'b0};
            step_in  = step_ff + 1'b1;
            if (step_ff == b2da_pkg::STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff <= value_in;
      bcd_ff   <= bcd_in;
      step_ff  <= step_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign handoff.valid = (state_ff == ST_DONE);
   assign handoff.bcd   = bcd_ff;

endmodule

FILE: hw/rtl/b2da_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_emit: decimal digit emitter
// Shifts the BCD digits out one per cycle unless stalled, most significant
// first, skips leading zeros and drives the registered result channel.
// ----------------------------------------------------------------------------
module b2da_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  b2da_pkg::handoff_type               handoff,
   output logic                                take,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [b2da_pkg::CHAR_WIDTH-1:0]     rsp_digit_char,
   output logic                                rsp_last_digit
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                              state_ff, state_in;
   logic [b2da_pkg::BCD_WIDTH-1:0]         bcd_ff, bcd_in;
   logic [b2da_pkg::COUNT_WIDTH-1:0]       remain_ff, remain_in;
   logic                                   started_ff, started_in;
   logic                                   valid_ff, valid_in;
   logic [b2da_pkg::CHAR_WIDTH-1:0]        char_ff, char_in;
   logic                                   last_ff, last_in;
   logic [b2da_pkg::DIGIT_WIDTH-1:0]       top_digit;
   logic                                   can_load;
   logic                                   one_left;

   assign top_digit = bcd_ff[b2da_pkg::BCD_WIDTH-1 -: b2da_pkg::DIGIT_WIDTH];
   assign can_load  = !valid_ff || !rsp_stall;
   assign one_left  = (remain_ff == b2da_pkg::COUNT_WIDTH'(1));
   assign take      = handoff.valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      bcd_in     = bcd_ff;
      remain_in  = remain_ff;
      started_in = started_ff;
      valid_in   = valid_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      if (can_load) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (handoff.valid) begin
               bcd_in     = handoff.bcd;
               remain_in  = b2da_pkg::COUNT_WIDTH'(b2da_pkg::DIGITS);
               started_in = 1'b0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (can_load) begin
               bcd_in    = bcd_ff << b2da_pkg::DIGIT_WIDTH;
               remain_in = remain_ff - 1'b1;
               if (started_ff || (top_digit != '0) || one_left) begin
                  valid_in   = 1'b1;
                  char_in    = b2da_pkg::ASCII_ZERO +
                               b2da_pkg::CHAR_WIDTH'(top_digit);
                  last_in    = one_left;
                  started_in = 1'b1;
               end
               if (one_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      bcd_ff     <= bcd_in;
      remain_ff  <= remain_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule

FILE: hw/rtl/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned 32-bit number to decimal ASCII digits
// The request channel takes one 32-bit word per number on req_value when
// req_valid is high and req_stall is low. The response channel returns the
// number's decimal digits as ASCII codes on rsp_digit_char, most significant
// first with leading zeros suppressed; rsp_last_digit marks the final digit.
// A zero yields the single character '0'.
// A number passes through the bit-serial BCD converter, then the emitter
// steps through all ten BCD digit slots, leading zeros included.
// The converter takes the next word once it has handed its digits to the
// emitter, so conversion overlaps emission.
// When the receiver raises rsp_stall, the current word holds on the outputs
// and the emitter waits; the converter finishes and then holds req_stall.
// Synchronous reset empties both stages and drops rsp_valid.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [b2da_pkg::CHAR_WIDTH-1:0]     rsp_digit_char,
   output logic                                rsp_last_digit
);

   b2da_pkg::handoff_type handoff;
   logic                  take;
   logic                  busy;

   assign req_stall = busy;

   b2da_dabble u_dabble (
      .clock   (clock),
      .reset   (reset),
      .start   (req_valid && !busy),
      .value   (req_value),
      .take    (take),
      .busy    (busy),
      .handoff (handoff)
   );

   b2da_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .handoff        (handoff),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the binary to decimal ASCII converter
// Numbers go in one word at a time. The bench predicts, or takes from a
// table, each number's decimal digit characters and checks them, in order,
// against the response words. A short table of edge values comes first, then
// random numbers with a mix of digit counts. Bursty requests, random response
// stalls and long response hold-offs exercise the back pressure.
// ----------------------------------------------------------------------------
module tb;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int RADIX          = 10;
   localparam int RANDOM_NUMBERS = 440;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 60;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int TABLE_ROWS     = 20;

   typedef struct packed {
      logic [b2da_pkg::CHAR_WIDTH-1:0] digit_char;
      logic                            last_digit;
   } digit_type;

   typedef struct {
      logic [b2da_pkg::VALUE_WIDTH-1:0] value;
      string                            text;
   } table_row_type;

   // An empty text means the row is checked against the predictor.
   table_row_type directed_rows [TABLE_ROWS] = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{32'd99,         "99"},
      '{32'd100,        "100"},
      '{32'd4294967295, "4294967295"},
      '{32'd4294967294, ""},
      '{32'd1000000000, "1000000000"},
      '{32'd999999999,  "999999999"},
      '{32'd1234567890, "1234567890"},
      '{32'd2147483647, ""},
      '{32'd2147483648, ""},
      '{32'hAAAAAAAA,   ""},
      '{32'h55555555,   ""},
      '{32'd4000000000, ""},
      '{32'd1000001,    ""},
      '{32'd3000000003, ""},
      '{32'd65536,      ""},
      '{32'd7,          "7"}
   };

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [b2da_pkg::VALUE_WIDTH-1:0] req_value = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [b2da_pkg::CHAR_WIDTH-1:0]  rsp_digit_char;
   logic                             rsp_last_digit;

   digit_type expected_digits [$];
   int     mismatches      = 0;
   int     numbers_sent    = 0;
   int     digits_checked  = 0;
   int     longest_number  = 0;
   int     digit_run       = 0;
   int     burst_left      = 0;
   int     holdoffs_done   = 0;
   int     cycle_count     = 0;
   bit     holdoff_request = 1'b0;

   binary_to_decimal_ascii u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic void predict_decimal_digits(
      input logic [b2da_pkg::VALUE_WIDTH-1:0] number);
      logic [b2da_pkg::DIGIT_WIDTH-1:0] slot [b2da_pkg::DIGITS];
      logic [b2da_pkg::VALUE_WIDTH-1:0] rest;
      int                               top;
      rest = number;
      top  = 0;
      for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
         slot[i] = b2da_pkg::DIGIT_WIDTH'(rest % RADIX);
         rest    = rest / RADIX;
      end
      for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
         if (slot[i] != 0) top = i;
      end
      for (int i = top; i >= 0; i--) begin
         expected_digits.push_back('{b2da_pkg::ASCII_ZERO +
                                     b2da_pkg::CHAR_WIDTH'(slot[i]), i == 0});
      end
   endfunction

   function automatic logic [b2da_pkg::VALUE_WIDTH-1:0] pick_value();
      longint unsigned low, high, scale;
      int              count;
      logic [b2da_pkg::VALUE_WIDTH-1:0] number;
      number = $urandom();
      scale  = 1;
      case ($urandom_range(0, 9))
         4, 5, 6: begin
            count = $urandom_range(1, 10);
            repeat (count - 1) scale *= RADIX;
            low  = (count == 1) ? 0 : scale;
            high = (count == 10) ? 64'hFFFFFFFF : scale * RADIX - 1;
            number = b2da_pkg::VALUE_WIDTH'(low +
                     ({$urandom(), $urandom()} % (high - low + 1)));
         end
         7, 8: begin
            repeat ($urandom_range(0, 9)) scale *= RADIX;
            number = b2da_pkg::VALUE_WIDTH'(scale + $urandom_range(0, 2) - 1);
         end
         9: begin
            scale = 0;
            repeat (9) begin
               scale = scale * RADIX +
                       (($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0);
            end
            if ($urandom_range(0, 1) == 1) scale += 64'd1000000000 * $urandom_range(1, 3);
            number = b2da_pkg::VALUE_WIDTH'(scale);
         end
         default: begin
         end
      endcase
      return number;
   endfunction

   task automatic send_number(input logic [b2da_pkg::VALUE_WIDTH-1:0] number,
                              input string text);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_value <= number;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      numbers_sent++;
      if (text.len() == 0) begin
         predict_decimal_digits(number);
      end else begin
         for (int i = 0; i < text.len(); i++) begin
            expected_digits.push_back('{b2da_pkg::CHAR_WIDTH'(text[i]),
                                        i == text.len() - 1});
         end
      end
   endtask

   // The receiver changes its stall rate in segments, some with no stalls at
   // all, and holds off completely whenever the stimulus asks for it.
   initial begin
      int percent;
      int segment_left;
      percent      = 0;
      segment_left = 0;
      forever begin
         @(posedge clock);
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            holdoffs_done++;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (segment_left == 0) begin
               segment_left = $urandom_range(20, 150);
               case ($urandom_range(0, 3))
                  0:       percent = 0;
                  1:       percent = 20;
                  2:       percent = 50;
                  default: percent = 85;
               endcase
            end
            segment_left--;
            rsp_stall <= ($urandom_range(0, 99) < percent);
         end
      end
   end

   always @(posedge clock) begin : check_digits
      digit_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_digits.size() == 0) begin
            $error("unexpected word: rsp_digit_char=%0d rsp_last_digit=%0b",
                   rsp_digit_char, rsp_last_digit);
            mismatches++;
         end else begin
            want = expected_digits.pop_front();
            if (rsp_digit_char !== want.digit_char) begin
               $error("rsp_digit_char: expected %0d, actual %0d",
                      want.digit_char, rsp_digit_char);
               mismatches++;
            end
            if (rsp_last_digit !== want.last_digit) begin
               $error("rsp_last_digit: expected %0b, actual %0b",
                      want.last_digit, rsp_last_digit);
               mismatches++;
            end
            digits_checked++;
            digit_run++;
            if (want.last_digit) begin
               if (digit_run > longest_number) longest_number = digit_run;
               digit_run = 0;
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) send_number(directed_rows[i].value, directed_rows[i].text);
      holdoff_request = 1'b1;
      for (int n = 0; n < RANDOM_NUMBERS; n++) begin
         if (n == RANDOM_NUMBERS / 2) holdoff_request = 1'b1;
         send_number(pick_value(), "");
      end
      req_valid <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Converted %0d numbers (%0d from the edge table), %0d digits checked,",
               numbers_sent, TABLE_ROWS, digits_checked);
      $display("longest number %0d digits, %0d response hold-offs of %0d cycles.",
               longest_number, holdoffs_done, HOLDOFF_CYCLES);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: binary_to_decimal_ascii.f
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_dabble.sv
hw/rtl/b2da_emit.sv
hw/rtl/binary_to_decimal_ascii.sv
tb/sv/tb.sv
